/* sv/rvdec_pkg.sv */
// ----------------------------------------------------------------------------
// rvdec_pkg
// Types and constants shared by the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

   typedef logic [6:0] opcode_type;
   typedef logic [2:0] format_type;
   typedef logic [2:0] class_type;
   typedef logic [5:0] op_code_type;

   localparam opcode_type OPC_LUI    = 7'b0110111;
   localparam opcode_type OPC_AUIPC  = 7'b0010111;
   localparam opcode_type OPC_JAL    = 7'b1101111;
   localparam opcode_type OPC_JALR   = 7'b1100111;
   localparam opcode_type OPC_BRANCH = 7'b1100011;
   localparam opcode_type OPC_LOAD   = 7'b0000011;
   localparam opcode_type OPC_OPIMM  = 7'b0010011;
   localparam opcode_type OPC_STORE  = 7'b0100011;
   localparam opcode_type OPC_OP     = 7'b0110011;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam format_type FMT_R       = 3'd0;
   localparam format_type FMT_I       = 3'd1;
   localparam format_type FMT_S       = 3'd2;
   localparam format_type FMT_B       = 3'd3;
   localparam format_type FMT_U       = 3'd4;
   localparam format_type FMT_J       = 3'd5;
   localparam format_type FMT_UNKNOWN = 3'd6;

   localparam class_type CLS_ARITH_REG = 3'd0;
   localparam class_type CLS_ARITH_IMM = 3'd1;
   localparam class_type CLS_LOAD      = 3'd2;
   localparam class_type CLS_STORE     = 3'd3;
   localparam class_type CLS_BRANCH    = 3'd4;
   localparam class_type CLS_OTHER     = 3'd5;

   localparam op_code_type OP_LUI   = 6'd0;
   localparam op_code_type OP_AUIPC = 6'd1;
   localparam op_code_type OP_JAL   = 6'd2;
   localparam op_code_type OP_JALR  = 6'd3;
   localparam op_code_type OP_BEQ   = 6'd4;
   localparam op_code_type OP_BNE   = 6'd5;
   localparam op_code_type OP_BLT   = 6'd6;
   localparam op_code_type OP_BGE   = 6'd7;
   localparam op_code_type OP_BLTU  = 6'd8;
   localparam op_code_type OP_BGEU  = 6'd9;
   localparam op_code_type OP_LB    = 6'd10;
   localparam op_code_type OP_LH    = 6'd11;
   localparam op_code_type OP_LW    = 6'd12;
   localparam op_code_type OP_LBU   = 6'd13;
   localparam op_code_type OP_LHU   = 6'd14;
   localparam op_code_type OP_SB    = 6'd15;
   localparam op_code_type OP_SH    = 6'd16;
   localparam op_code_type OP_SW    = 6'd17;
   localparam op_code_type OP_ADDI  = 6'd18;
   localparam op_code_type OP_SLTI  = 6'd19;
   localparam op_code_type OP_SLTIU = 6'd20;
   localparam op_code_type OP_XORI  = 6'd21;
   localparam op_code_type OP_ORI   = 6'd22;
   localparam op_code_type OP_ANDI  = 6'd23;
   localparam op_code_type OP_SLLI  = 6'd24;
   localparam op_code_type OP_SRLI  = 6'd25;
   localparam op_code_type OP_SRAI  = 6'd26;
   localparam op_code_type OP_ADD   = 6'd27;
   localparam op_code_type OP_SUB   = 6'd28;
   localparam op_code_type OP_SLL   = 6'd29;
   localparam op_code_type OP_SLT   = 6'd30;
   localparam op_code_type OP_SLTU  = 6'd31;
   localparam op_code_type OP_XOR   = 6'd32;
   localparam op_code_type OP_SRL   = 6'd33;
   localparam op_code_type OP_SRA   = 6'd34;
   localparam op_code_type OP_OR    = 6'd35;
   localparam op_code_type OP_AND   = 6'd36;
   localparam op_code_type OP_BAD   = 6'd37;

   typedef struct packed {
      format_type  format_kind;
      class_type   issue_class;
      op_code_type op_code;
      logic [4:0]  dest_reg;
      logic        dest_valid;
      logic [4:0]  src1_reg;
      logic        src1_used;
      logic [4:0]  src2_reg;
      logic        src2_used;
      logic [31:0] immediate;
   } dec_result_type;

   function automatic op_code_type branch_op(input logic [2:0] f3);
      op_code_type op;
      case (f3)
         3'd0: op = OP_BEQ;
         3'd1: op = OP_BNE;
         3'd4: op = OP_BLT;
         3'd5: op = OP_BGE;
         3'd6: op = OP_BLTU;
         3'd7: op = OP_BGEU;
         default: op = OP_BAD;
      endcase
      return op;
   endfunction

   function automatic op_code_type load_op(input logic [2:0] f3);
      op_code_type op;
      case (f3)
         3'd0: op = OP_LB;
         3'd1: op = OP_LH;
         3'd2: op = OP_LW;
         3'd4: op = OP_LBU;
         3'd5: op = OP_LHU;
         default: op = OP_BAD;
      endcase
      return op;
   endfunction

   function automatic op_code_type store_op(input logic [2:0] f3);
      op_code_type op;
      case (f3)
         3'd0: op = OP_SB;
         3'd1: op = OP_SH;
         3'd2: op = OP_SW;
         default: op = OP_BAD;
      endcase
      return op;
   endfunction

   function automatic op_code_type opimm_op(input logic [2:0] f3, input logic [6:0] f7);
      op_code_type op;
      case (f3)
         3'd0: op = OP_ADDI;
         3'd1: op = (f7 == F7_BASE) ? OP_SLLI : OP_BAD;
         3'd2: op = OP_SLTI;
         3'd3: op = OP_SLTIU;
         3'd4: op = OP_XORI;
         3'd5: op = (f7 == F7_BASE) ? OP_SRLI : ((f7 == F7_ALT) ? OP_SRAI : OP_BAD);
         3'd6: op = OP_ORI;
         3'd7: op = OP_ANDI;
         default: op = OP_BAD;
      endcase
      return op;
   endfunction

   function automatic op_code_type reg_op(input logic [2:0] f3, input logic [6:0] f7);
      op_code_type op;
      op = OP_BAD;
      if (f7 == F7_BASE) begin
         case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            3'd7: op = OP_AND;
            default: op = OP_BAD;
         endcase
      end else if (f7 == F7_ALT) begin
         case (f3)
            3'd0: op = OP_SUB;
            3'd5: op = OP_SRA;
            default: op = OP_BAD;
         endcase
      end
      return op;
   endfunction

endpackage

/* sv/rv32i_instruction_decoder.sv */
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Splits an RV32I instruction word into format, class, operation, register
// fields and the immediate, sign-extended except for shift amounts.
//
// Channels: req_* carries one instruction word per transaction, rsp_* one
// decoded result. A transaction moves on a rising edge with valid high and
// stall low. The receiver of each channel drives its stall.
// Path: an accepted word is held in the input register, decoded by shallow
// logic and captured in the result register, from which it can be taken;
// rsp_valid rises when the word enters the result register.
// Throughput: one transaction per cycle while the result is not stalled, set
// by the two register stages advancing together.
// Reset: clears both stage valid flags; no result is presented until a new
// transaction has passed both stages.
// Stall: a stalled result holds in the result register; the input register
// keeps filling, and req_stall rises only when both stages are full and the
// result is stalled.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_instr_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rvdec_pkg::format_type     rsp_format_kind,
   output rvdec_pkg::class_type      rsp_issue_class,
   output rvdec_pkg::op_code_type    rsp_op_code,
   output logic [4:0]                rsp_dest_reg,
   output logic                      rsp_dest_valid,
   output logic [4:0]                rsp_src1_reg,
   output logic                      rsp_src1_used,
   output logic [4:0]                rsp_src2_reg,
   output logic                      rsp_src2_used,
   output logic signed [31:0]        rsp_immediate
);
   import rvdec_pkg::*;

   logic           word_valid_ff;
   logic           word_valid_in;
   logic [31:0]    word_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   dec_result_type rsp_ff;
   dec_result_type rsp_in;
   logic           rsp_load;
   logic           word_load;

   assign rsp_load      = !rsp_valid_ff || !rsp_stall;
   assign word_load     = !word_valid_ff || rsp_load;
   assign req_stall     = !word_load;
   assign word_valid_in = word_load ? req_valid : word_valid_ff;
   assign rsp_valid_in  = rsp_load ? word_valid_ff : rsp_valid_ff;

   always_comb begin
      logic [6:0] opc;
      logic [2:0] f3;
      logic [6:0] f7;
      logic [31:0] imm_i;
      opc   = word_ff[6:0];
      f3    = word_ff[14:12];
      f7    = word_ff[31:25];
      imm_i = {{20{word_ff[31]}}, word_ff[31:20]};
      rsp_in = '0;
      rsp_in.format_kind = FMT_UNKNOWN;
      rsp_in.issue_class = CLS_OTHER;
      rsp_in.op_code     = OP_BAD;
      case (opc)
         OPC_LUI: begin
            rsp_in.format_kind = FMT_U;
            rsp_in.op_code     = OP_LUI;
            rsp_in.dest_valid  = 1'b1;
            rsp_in.immediate   = {word_ff[31:12], 12'd0};
         end
         OPC_AUIPC: begin
            rsp_in.format_kind = FMT_U;
            rsp_in.op_code     = OP_AUIPC;
            rsp_in.dest_valid  = 1'b1;
            rsp_in.immediate   = {word_ff[31:12], 12'd0};
         end
         OPC_JAL: begin
            rsp_in.format_kind = FMT_J;
            rsp_in.op_code     = OP_JAL;
            rsp_in.dest_valid  = 1'b1;
            rsp_in.immediate   = {{12{word_ff[31]}}, word_ff[19:12], word_ff[20],
                                  word_ff[30:21], 1'b0};
         end
         OPC_JALR: begin
            rsp_in.format_kind = FMT_I;
            rsp_in.op_code     = (f3 == 3'd0) ? OP_JALR : OP_BAD;
            rsp_in.dest_valid  = 1'b1;
            rsp_in.src1_used   = 1'b1;
            rsp_in.immediate   = imm_i;
         end
         OPC_BRANCH: begin
            rsp_in.format_kind = FMT_B;
            rsp_in.issue_class = CLS_BRANCH;
            rsp_in.op_code     = branch_op(f3);
            rsp_in.src1_used   = 1'b1;
            rsp_in.src2_used   = 1'b1;
            rsp_in.immediate   = {{20{word_ff[31]}}, word_ff[7], word_ff[30:25],
                                  word_ff[11:8], 1'b0};
         end
         OPC_LOAD: begin
            rsp_in.format_kind = FMT_I;
            rsp_in.issue_class = CLS_LOAD;
            rsp_in.op_code     = load_op(f3);
            rsp_in.dest_valid  = 1'b1;
            rsp_in.src1_used   = 1'b1;
            rsp_in.immediate   = imm_i;
         end
         OPC_STORE: begin
            rsp_in.format_kind = FMT_S;
            rsp_in.issue_class = CLS_STORE;
            rsp_in.op_code     = store_op(f3);
            rsp_in.src1_used   = 1'b1;
            rsp_in.src2_used   = 1'b1;
            rsp_in.immediate   = {{20{word_ff[31]}}, word_ff[31:25], word_ff[11:7]};
         end
         OPC_OPIMM: begin
            rsp_in.format_kind = FMT_I;
            rsp_in.issue_class = CLS_ARITH_IMM;
            rsp_in.op_code     = opimm_op(f3, f7);
            rsp_in.dest_valid  = 1'b1;
            rsp_in.src1_used   = 1'b1;
            if (f3 == 3'd1 || f3 == 3'd5) begin
               rsp_in.immediate = {27'd0, word_ff[24:20]};
            end else begin
               rsp_in.immediate = imm_i;
            end
         end
         OPC_OP: begin
            rsp_in.format_kind = FMT_R;
            rsp_in.issue_class = CLS_ARITH_REG;
            rsp_in.op_code     = reg_op(f3, f7);
            rsp_in.dest_valid  = 1'b1;
            rsp_in.src1_used   = 1'b1;
            rsp_in.src2_used   = 1'b1;
         end
         default: begin
            rsp_in.format_kind = FMT_UNKNOWN;
         end
      endcase
      rsp_in.dest_reg = rsp_in.dest_valid ? word_ff[11:7]  : 5'd0;
      rsp_in.src1_reg = rsp_in.src1_used  ? word_ff[19:15] : 5'd0;
      rsp_in.src2_reg = rsp_in.src2_used  ? word_ff[24:20] : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_load) begin
         word_ff <= req_instr_word;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_format_kind = rsp_ff.format_kind;
   assign rsp_issue_class = rsp_ff.issue_class;
   assign rsp_op_code     = rsp_ff.op_code;
   assign rsp_dest_reg    = rsp_ff.dest_reg;
   assign rsp_dest_valid  = rsp_ff.dest_valid;
   assign rsp_src1_reg    = rsp_ff.src1_reg;
   assign rsp_src1_used   = rsp_ff.src1_used;
   assign rsp_src2_reg    = rsp_ff.src2_reg;
   assign rsp_src2_used   = rsp_ff.src2_used;
   assign rsp_immediate   = $signed(rsp_ff.immediate);

endmodule
